[src/lta_pkg.sv]
// Shared types and constants for the last-touch attribution block.
// Holds field widths, operation codes and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package lta_pkg;

  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 16;
  localparam int BKT_W   = 7;
  localparam int TOTAL_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // request accepted this cycle
    logic sweep_step;   // zero one bucket and advance the sweep counter
    logic credit_wr;    // write the saturated credit back
    logic out_load;     // load the read result into the output register
  } lta_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic credit_needed;
    logic sweep_done;
    logic out_free;
  } lta_sts_t;

endpackage

`default_nettype wire

[src/lta_if.sv]
// Valid/ready channel interfaces for request and result traffic.
// Depends on lta_pkg for field widths.
`default_nettype none

interface lta_in_if;
  logic                       valid;
  logic                       ready;
  logic [lta_pkg::FUNC_W-1:0] func;
  logic [lta_pkg::KEY_W-1:0]  user_key;
  logic                       trigger_flag;
  logic [lta_pkg::VAL_W-1:0]  trigger_value;
  logic [lta_pkg::BKT_W-1:0]  bucket_index;

  modport source (output valid, func, user_key, trigger_flag, trigger_value,
                  bucket_index, input ready);
  modport sink (input valid, func, user_key, trigger_flag, trigger_value,
                bucket_index, output ready);
endinterface

interface lta_out_if;
  logic                        valid;
  logic                        ready;
  logic [lta_pkg::TOTAL_W-1:0] bucket_total;

  modport source (output valid, bucket_total, input ready);
  modport sink (input valid, bucket_total, output ready);
endinterface

`default_nettype wire

[src/lta_ctrl.sv]
// Controller state machine: request acceptance, clearing sweep,
// credit write-back and result hand-off. Depends on lta_pkg.
`default_nettype none

module lta_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lta_pkg::lta_sts_t sts,
  output lta_pkg::lta_cmd_t      cmd
);
  import lta_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CLEAR  = 2'd1;
  localparam logic [1:0] ST_RESP   = 2'd2;
  localparam logic [1:0] ST_CREDIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          if (sts.is_clear) begin
            state_nxt = ST_CLEAR;
          end else if (sts.is_read) begin
            state_nxt = ST_RESP;
          end else if (sts.credit_needed) begin
            state_nxt = ST_CREDIT;
          end
        end
      end
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        // Hold the read data until the output register can take it.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CREDIT: begin
        cmd.credit_wr = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Reset starts a sweep that zeroes every bucket total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[src/lta_datapath.sv]
// Datapath: bucket total memory, key tracking, saturating credit adder
// and output register. Depends on lta_pkg and lta_if.
`default_nettype none

module lta_datapath #(
  parameter int NUM_BUCKETS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lta_in_if.sink                 in_chan,
  lta_out_if.source              out_chan,
  input  wire lta_pkg::lta_cmd_t cmd,
  output lta_pkg::lta_sts_t      sts
);
  import lta_pkg::*;

  localparam int AW    = $clog2(NUM_BUCKETS);
  localparam int EXT_W = AW + BKT_W;

  logic [TOTAL_W-1:0] mem [NUM_BUCKETS];

  logic [KEY_W-1:0]   key_r;
  logic               seen_r;
  logic [BKT_W-1:0]   src_bkt_r;
  logic [AW-1:0]      sweep_cnt_r;
  logic [TOTAL_W-1:0] rd_data_r;
  logic               rd_zero_r;
  logic [AW-1:0]      wr_addr_r;
  logic [VAL_W-1:0]   value_r;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic               is_event;
  logic               seen_eff;
  logic               src_in_range;
  logic               req_in_range;
  logic [EXT_W-1:0]   src_ext;
  logic [EXT_W-1:0]   req_ext;
  logic [AW-1:0]      rd_addr;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] sum_sat;

  assign is_event     = (in_chan.func == FUNC_EVENT);
  // A row with a new key forgets the remembered source.
  assign seen_eff     = seen_r && (in_chan.user_key == key_r);
  assign src_in_range = (32'(src_bkt_r) < 32'(NUM_BUCKETS));
  assign req_in_range = (32'(in_chan.bucket_index) < 32'(NUM_BUCKETS));
  assign src_ext      = EXT_W'(src_bkt_r);
  assign req_ext      = EXT_W'(in_chan.bucket_index);
  assign rd_addr      = (in_chan.func == FUNC_READ) ? req_ext[AW-1:0] : src_ext[AW-1:0];

  assign sum     = {1'b0, rd_data_r} + (TOTAL_W + 1)'(value_r);
  assign sum_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign sts.is_clear      = (in_chan.func == FUNC_CLEAR);
  assign sts.is_read       = (in_chan.func == FUNC_READ);
  assign sts.credit_needed = is_event && in_chan.trigger_flag && seen_eff && src_in_range;
  assign sts.sweep_done    = (sweep_cnt_r == AW'(NUM_BUCKETS - 1));
  assign sts.out_free      = !out_valid_r || out_chan.ready;

  // Memory: one write port shared by the sweep and the credit, one read port.
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem[sweep_cnt_r] <= '0;
    end else if (cmd.credit_wr) begin
      mem[wr_addr_r] <= sum_sat;
    end
    if (cmd.take) begin
      rd_data_r <= mem[rd_addr];
      rd_zero_r <= !req_in_range;
      wr_addr_r <= src_ext[AW-1:0];
      value_r   <= in_chan.trigger_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_cnt_r <= sts.sweep_done ? '0 : sweep_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      seen_r    <= 1'b0;
      src_bkt_r <= '0;
    end else if (cmd.take) begin
      if (sts.is_clear) begin
        key_r     <= '0;
        seen_r    <= 1'b0;
        src_bkt_r <= '0;
      end else if (is_event) begin
        key_r <= in_chan.user_key;
        if (in_chan.trigger_flag) begin
          seen_r <= seen_eff;
        end else begin
          seen_r    <= 1'b1;
          src_bkt_r <= in_chan.bucket_index;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_total_r <= rd_zero_r ? '0 : rd_data_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.bucket_total = out_total_r;

endmodule

`default_nettype wire

[src/last_touch_attribution_top.sv]
// Last-touch attribution top level: controller plus datapath.
// Source rows and ignored codes leave the controller idle; a credited trigger
// passes through the credit write-back state. A read waits in the response
// state until the output register is free; its result passes the registered
// memory read port and waits in an output register. A clear sweep zeroes one
// bucket per cycle; after reset the same sweep runs with in ready held low.
`default_nettype none

module last_touch_attribution_top #(
  parameter int NUM_BUCKETS = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lta_in_if.sink     in_chan,
  lta_out_if.source  out_chan
);
  import lta_pkg::*;

  lta_cmd_t cmd;
  lta_sts_t sts;

  lta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lta_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire

[src/lta_checker.sv]
// Port-level checks for the last-touch attribution top level, and the bind
// that attaches them. Depends on lta_pkg and last_touch_attribution_top.
`default_nettype none

module lta_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [lta_pkg::FUNC_W-1:0]  in_func,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lta_pkg::TOTAL_W-1:0] out_bucket_total
);
  import lta_pkg::*;

  logic in_take;
  assign in_take = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bucket_total))
    else $error("result payload changed while stalled");

  // An event row never produces a result.
  a_event_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (in_func == FUNC_EVENT) && !out_valid |=> !out_valid)
    else $error("event row produced a result");

  // A clear request starts the sweep, so no request is taken right after it.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (in_func == FUNC_CLEAR) |=> !in_ready)
    else $error("request accepted during clear sweep");

endmodule

bind last_touch_attribution_top lta_checker u_lta_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_func          (in_chan.func),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_bucket_total (out_chan.bucket_total)
);

`default_nettype wire
